// ----- rtl/stable_matching_verifier_assert.svh -----
// assertion macros for the stable matching verifier checker
// no dependencies; included by the checker file
`ifndef STABLE_MATCHING_VERIFIER_ASSERT_SVH
`define STABLE_MATCHING_VERIFIER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SMV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/smv_pkg.sv -----
// shared types and constants for the stable matching verifier
// no dependencies; used by the top level and its checker
`default_nettype none

package smv_pkg;

  localparam int MAX_PAIRS = 16;
  localparam int IdxW      = $clog2(MAX_PAIRS);
  localparam int CntW      = $clog2(MAX_PAIRS + 1);
  localparam int MemDepth  = MAX_PAIRS * MAX_PAIRS;
  localparam int AddrW     = 2 * IdxW;

  typedef enum logic [1:0] {
    ACT_LOAD_HOSP  = 2'd0,
    ACT_LOAD_STUD  = 2'd1,
    ACT_LOAD_MATCH = 2'd2,
    ACT_CHECK      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_STABLE   = 2'd0,
    STAT_BAD_HOSP = 2'd1,
    STAT_DUP_HOSP = 2'd2,
    STAT_UNSTABLE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VAL,
    ST_RANK_RD,
    ST_RANK_CMP,
    ST_DONE
  } state_e;

  // which list search the rank unit is running
  typedef enum logic [1:0] {
    JOB_HPART,
    JOB_HS,
    JOB_SH,
    JOB_SM
  } job_e;

endpackage

`default_nettype wire

// ----- rtl/stable_matching_verifier.sv -----
// top level of the stable matching verifier: preference stores, matching store,
// sequencer and shared rank-search unit; depends on smv_pkg
//
// usage:
//   config: cfg_we_i/cfg_wdata_i write pairs_in_use (n) directly, no wait.
//     values above 16 act as 16; write only while the block is idle.
//   input channel (in_valid_i/in_ready_o): one beat is a load or a check.
//     loads (hospital list entry, student list entry, matching entry) are
//     taken one per cycle while the block is idle and give no output beat.
//   a check gives exactly one output beat (status, bad_hospital, bad_student).
//     steps: validation pass over the n matching entries, then per hospital
//     one partner rank search and per pair up to three list searches; each
//     search reads its list entries one at a time from the hospital or student
//     store and compares each through the single shared comparator; with
//     n = 0 the check goes straight to the verdict.
//   in_ready_o is low from check acceptance until the verdict is moved into
//     the output register.
//   output channel (out_valid_o/out_ready_i): the verdict sits in an output
//     register; loads keep being accepted while it waits. a stalled receiver
//     only holds back the end of the next check.
//   reset: n returns to 16, the output register empties, the sequencer idles.
//     list and matching stores are not cleared and must be written first.
`default_nettype none

module stable_matching_verifier
  import smv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire logic [3:0] row_i,
  input  wire logic [3:0] position_i,
  input  wire logic [7:0] value_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [7:0]      bad_hospital_o,
  output logic [4:0]      bad_student_o
);

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  job_e                job_q, job_d;
  logic [4:0]          cfg_q;
  logic [CntW-1:0]     n_q, n_d;
  logic [IdxW-1:0]     i_q, i_d;          // validation index (student)
  logic [IdxW-1:0]     h_q, h_d;          // hospital index, outer loop
  logic [IdxW-1:0]     s_q, s_d;          // student index, inner loop
  logic [IdxW-1:0]     p_q, p_d;          // list position of the rank search
  logic [MAX_PAIRS-1:0] seen_q, seen_d;
  logic [CntW-1:0]     rpart_q, rpart_d;  // rank of own partner in hospital list
  logic [CntW-1:0]     rsh_q, rsh_d;      // rank of h in student list
  status_e             res_status_q, res_status_d;
  logic [7:0]          res_hosp_q, res_hosp_d;
  logic [4:0]          res_stud_q, res_stud_d;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [7:0]          out_hosp_q;
  logic [4:0]          out_stud_q;

  // stores
  logic [7:0]          hosp_mem [MemDepth];
  logic [7:0]          stud_mem [MemDepth];
  logic [7:0]          hosp_rd_q, stud_rd_q;
  logic [7:0]          match_q [MAX_PAIRS];
  logic [CntW-1:0]     partner_q [MAX_PAIRS];   // one-based student of each hospital

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  logic                in_fire;
  logic                row_ok, pos_ok;
  logic [IdxW-1:0]     wr_row, wr_pos;
  logic [AddrW-1:0]    wr_addr;
  logic                hosp_we, stud_we, match_we, check_go;
  logic [CntW-1:0]     n_eff;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign row_ok     = 32'(row_i) < MAX_PAIRS;
  assign pos_ok     = 32'(position_i) < MAX_PAIRS;
  assign wr_row     = IdxW'(row_i);
  assign wr_pos     = IdxW'(position_i);
  assign wr_addr    = {wr_row, wr_pos};
  assign hosp_we    = in_fire && (action_i == ACT_LOAD_HOSP) && row_ok && pos_ok;
  assign stud_we    = in_fire && (action_i == ACT_LOAD_STUD) && row_ok && pos_ok;
  assign match_we   = in_fire && (action_i == ACT_LOAD_MATCH) && row_ok;
  assign check_go   = in_fire && (action_i == ACT_CHECK);
  assign n_eff      = (32'(cfg_q) > MAX_PAIRS) ? CntW'(MAX_PAIRS) : CntW'(cfg_q);

  // ---------------------------------------------------------------------------
  // validation pass: one matching entry per cycle
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0]     match_idx;
  logic [7:0]          match_rd;
  logic [IdxW-1:0]     m_idx;
  logic                val_bad, val_dup, i_last;

  // single read address: validation index, else the inner-loop student
  assign match_idx = (state_q == ST_VAL) ? i_q : s_q;
  assign match_rd  = match_q[match_idx];
  assign m_idx     = IdxW'(match_rd - 8'd1);
  assign val_bad   = (match_rd == 8'd0) || (32'(match_rd) > 32'(n_q));
  assign val_dup   = seen_q[m_idx];
  assign i_last    = (CntW'(i_q) + CntW'(1)) == n_q;

  // ---------------------------------------------------------------------------
  // shared rank-search unit: one list entry read, then compared
  // rank code 0 means unlisted (ahead of all), p+1 means found at position p
  // ---------------------------------------------------------------------------
  logic                srch_stud;
  logic [IdxW-1:0]     srch_row;
  logic [7:0]          srch_tgt;
  logic [AddrW-1:0]    rd_addr;
  logic [7:0]          srch_rd;
  logic                srch_hit, p_last, srch_end;
  logic [CntW-1:0]     rank_now;

  always_comb begin
    srch_stud = 1'b0;
    srch_row  = h_q;
    srch_tgt  = 8'(partner_q[h_q]);
    case (job_q)
      JOB_HPART: begin
        srch_stud = 1'b0;
        srch_row  = h_q;
        srch_tgt  = 8'(partner_q[h_q]);
      end
      JOB_HS: begin
        srch_stud = 1'b0;
        srch_row  = h_q;
        srch_tgt  = 8'(CntW'(s_q) + CntW'(1));
      end
      JOB_SH: begin
        srch_stud = 1'b1;
        srch_row  = s_q;
        srch_tgt  = 8'(CntW'(h_q) + CntW'(1));
      end
      JOB_SM: begin
        srch_stud = 1'b1;
        srch_row  = s_q;
        srch_tgt  = match_rd;
      end
      default: begin
        srch_stud = 1'b0;
        srch_row  = h_q;
        srch_tgt  = 8'(partner_q[h_q]);
      end
    endcase
  end

  assign rd_addr  = {srch_row, p_q};
  assign srch_rd  = srch_stud ? stud_rd_q : hosp_rd_q;
  assign srch_hit = (srch_rd == srch_tgt);
  assign p_last   = (CntW'(p_q) + CntW'(1)) == n_q;
  assign srch_end = srch_hit || p_last;
  assign rank_now = srch_hit ? (CntW'(p_q) + CntW'(1)) : '0;

  // pair loop decisions at the end of a search
  logic                h_last, s_last;
  logic                hs_ahead, pair_found, pair_done, advance, all_done;

  assign h_last     = (CntW'(h_q) + CntW'(1)) == n_q;
  assign s_last     = (CntW'(s_q) + CntW'(1)) == n_q;
  assign hs_ahead   = rank_now < rpart_q;
  assign pair_found = (job_q == JOB_SM) && (rsh_q < rank_now);
  // pair rejected: hospital side not ahead, or student side not ahead
  assign pair_done  = ((job_q == JOB_HS) && !hs_ahead) ||
                      ((job_q == JOB_SM) && !pair_found);
  assign advance    = srch_end && pair_done;
  assign all_done   = advance && s_last && h_last;

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  logic                out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (check_go) begin
          state_d = (n_eff == '0) ? ST_DONE : ST_VAL;
        end
      end
      ST_VAL: begin
        if (val_bad || val_dup) begin
          state_d = ST_DONE;
        end else if (i_last) begin
          state_d = ST_RANK_RD;
        end
      end
      ST_RANK_RD: begin
        state_d = ST_RANK_CMP;
      end
      ST_RANK_CMP: begin
        if (srch_end && (pair_found || all_done)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RANK_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: datapath updates
  // ---------------------------------------------------------------------------
  always_comb begin
    job_d        = job_q;
    n_d          = n_q;
    i_d          = i_q;
    h_d          = h_q;
    s_d          = s_q;
    p_d          = p_q;
    seen_d       = seen_q;
    rpart_d      = rpart_q;
    rsh_d        = rsh_q;
    res_status_d = res_status_q;
    res_hosp_d   = res_hosp_q;
    res_stud_d   = res_stud_q;
    case (state_q)
      ST_IDLE: begin
        if (check_go) begin
          n_d          = n_eff;
          i_d          = '0;
          seen_d       = '0;
          res_status_d = STAT_STABLE;
          res_hosp_d   = 8'd0;
          res_stud_d   = 5'd0;
        end
      end
      ST_VAL: begin
        if (val_bad) begin
          res_status_d = STAT_BAD_HOSP;
          res_hosp_d   = match_rd;
        end else if (val_dup) begin
          res_status_d = STAT_DUP_HOSP;
          res_hosp_d   = match_rd;
        end else begin
          seen_d[m_idx] = 1'b1;
          i_d           = i_q + IdxW'(1);
          if (i_last) begin
            // start with hospital 1: rank its own partner
            h_d   = '0;
            p_d   = '0;
            job_d = JOB_HPART;
          end
        end
      end
      ST_RANK_CMP: begin
        if (!srch_end) begin
          p_d = p_q + IdxW'(1);
        end else begin
          p_d = '0;
          case (job_q)
            JOB_HPART: begin
              rpart_d = rank_now;
              s_d     = '0;
              job_d   = JOB_HS;
            end
            JOB_HS: begin
              if (hs_ahead) begin
                job_d = JOB_SH;
              end
            end
            JOB_SH: begin
              rsh_d = rank_now;
              job_d = JOB_SM;
            end
            JOB_SM: begin
              if (pair_found) begin
                res_status_d = STAT_UNSTABLE;
                res_hosp_d   = 8'(CntW'(h_q) + CntW'(1));
                res_stud_d   = 5'(CntW'(s_q) + CntW'(1));
              end
            end
            default: begin
              job_d = JOB_HPART;
            end
          endcase
          if (advance && !all_done) begin
            if (s_last) begin
              h_d   = h_q + IdxW'(1);
              job_d = JOB_HPART;
            end else begin
              s_d   = s_q + IdxW'(1);
              job_d = JOB_HS;
            end
          end
        end
      end
      default: begin
        job_d = job_q;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      job_q        <= JOB_HPART;
      cfg_q        <= 5'd16;
      n_q          <= '0;
      i_q          <= '0;
      h_q          <= '0;
      s_q          <= '0;
      p_q          <= '0;
      seen_q       <= '0;
      rpart_q      <= '0;
      rsh_q        <= '0;
      res_status_q <= STAT_STABLE;
      res_hosp_q   <= 8'd0;
      res_stud_q   <= 5'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      job_q        <= job_d;
      n_q          <= n_d;
      i_q          <= i_d;
      h_q          <= h_d;
      s_q          <= s_d;
      p_q          <= p_d;
      seen_q       <= seen_d;
      rpart_q      <= rpart_d;
      rsh_q        <= rsh_d;
      res_status_q <= res_status_d;
      res_hosp_q   <= res_hosp_d;
      res_stud_q   <= res_stud_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload, loaded when the verdict moves out of the sequencer
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_status_q <= res_status_q;
      out_hosp_q   <= res_hosp_q;
      out_stud_q   <= res_stud_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign bad_hospital_o = out_hosp_q;
  assign bad_student_o  = out_stud_q;

  // ---------------------------------------------------------------------------
  // stores
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (hosp_we) begin
      hosp_mem[wr_addr] <= value_i;
    end
    hosp_rd_q <= hosp_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stud_we) begin
      stud_mem[wr_addr] <= value_i;
    end
    stud_rd_q <= stud_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (match_we) begin
      match_q[wr_row] <= value_i;
    end
  end

  // partner of each hospital, recorded during the validation pass
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_VAL) && !val_bad && !val_dup) begin
      partner_q[m_idx] <= CntW'(i_q) + CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smv_checker.sv -----
// port-level checker for the stable matching verifier, bound to the top level
// depends on smv_pkg and stable_matching_verifier_assert.svh
`default_nettype none

`include "stable_matching_verifier_assert.svh"

module smv_checker
  import smv_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [1:0] action_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] status_o,
  input wire logic [7:0] bad_hospital_o,
  input wire logic [4:0] bad_student_o
);

  logic load_beat, check_beat, out_seen;

  assign load_beat  = in_valid_i && in_ready_o && (action_i != ACT_CHECK);
  assign check_beat = in_valid_i && in_ready_o && (action_i == ACT_CHECK);
  assign out_seen   = out_valid_o;

  // a pending output beat holds until taken
  `SMV_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output beat dropped")

  // a load leaves the block ready in the following cycle
  `SMV_ASSERT_NEXT(a_load_ready, load_beat, in_ready_o, "not ready after load beat")

  // a check leaves the block busy in the following cycle
  `SMV_ASSERT_NEXT(a_check_busy, check_beat, !in_ready_o, "ready right after check beat")

  // a stable verdict carries no offender
  `SMV_ASSERT_NOW(a_stable_zero, out_seen && (status_o == STAT_STABLE),
                  (bad_hospital_o == 8'd0) && (bad_student_o == 5'd0),
                  "stable verdict not zero")

  // an unstable verdict names a real pair
  `SMV_ASSERT_NOW(a_unstable_pair, out_seen && (status_o == STAT_UNSTABLE),
                  (bad_hospital_o != 8'd0) && (bad_student_o != 5'd0),
                  "unstable pair is empty")

endmodule

bind stable_matching_verifier smv_checker u_smv_checker (.*);

`default_nettype wire
